[rtl/bfnc_pkg.sv]
package bfnc_pkg;

   // Field widths fixed by the interface
   localparam int NODE_BITS   = 10;
   localparam int WEIGHT_BITS = 16;
   localparam int COST_BITS   = 48;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int CSR_BITS    = 2;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SOLVE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_UNREACH  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FINITE   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NEG_INF  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd3;

   // Control register indexes
   localparam logic [CSR_BITS-1:0] CSR_NODE_COUNT  = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_SOURCE_NODE = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_TARGET_NODE = 2'd2;

   // One stored edge
   typedef struct packed {
      logic [NODE_BITS-1:0]          src;
      logic [NODE_BITS-1:0]          dst;
      logic signed [WEIGHT_BITS-1:0] weight;
   } edge_type;

endpackage

[rtl/bfnc_edge_store.sv]
module bfnc_edge_store import bfnc_pkg::*; #(
   parameter int MAX_EDGES = 4096
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_EDGES)-1:0] wr_addr,
   input  edge_type                     wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_EDGES)-1:0] rd_addr,
   output edge_type                     rd_data
);

   edge_type mem [0:MAX_EDGES-1];
   edge_type rd_data_ff;

   // Write one edge, read one edge with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bellman_ford_neg_cycle_reach_top.sv]
// Load stores an edge on transfer (and its reversed copy in S_REV if two-way);
// clear and reset (synchronous, active high) empty the store. Solve, after an
// overflow, goes straight to S_REPORT; else S_CLR clears node entries 0..MAX_NODES,
// S_SRC seeds the source; sweeps walk the stored edges, skipping out-of-range ones,
// over min(node_count, MAX_NODES)-1 relaxation sweeps, one check sweep and the
// mark-spreading sweeps, then reports once the output is free. One item at a time.
module bellman_ford_neg_cycle_reach_top import bfnc_pkg::*; #(
   parameter int MAX_NODES = 512,
   parameter int MAX_EDGES = 4096,
   parameter int DIST_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [CMD_BITS-1:0]           req_cmd,
   input  logic [NODE_BITS-1:0]          req_edge_from,
   input  logic [NODE_BITS-1:0]          req_edge_to,
   input  logic signed [WEIGHT_BITS-1:0] req_edge_weight,
   input  logic                          req_both_ways,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [STATUS_BITS-1:0]        rsp_path_status,
   output logic signed [COST_BITS-1:0]   rsp_path_cost,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_BITS-1:0]           csr_index,
   input  logic [NODE_BITS-1:0]          csr_data
);

   localparam int EW = $clog2(MAX_EDGES);
   localparam int TW = $clog2(MAX_EDGES + 1);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int CW = (NW > NODE_BITS) ? NW : NODE_BITS;
   localparam int DW = DIST_BITS;
   localparam int XW = (DW > COST_BITS) ? DW : COST_BITS;
   localparam int MW = DW + 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_REV    = 4'd1;
   localparam logic [3:0] S_CLR    = 4'd2;
   localparam logic [3:0] S_SRC    = 4'd3;
   localparam logic [3:0] S_EDGE   = 4'd4;
   localparam logic [3:0] S_EW     = 4'd5;
   localparam logic [3:0] S_NW     = 4'd6;
   localparam logic [3:0] S_CMP    = 4'd7;
   localparam logic [3:0] S_TGT    = 4'd8;
   localparam logic [3:0] S_TW     = 4'd9;
   localparam logic [3:0] S_REPORT = 4'd10;

   localparam logic [1:0] PH_RELAX  = 2'd0;
   localparam logic [1:0] PH_CHECK  = 2'd1;
   localparam logic [1:0] PH_SPREAD = 2'd2;

   localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DIST_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [XW-1:0] COST_MAX_X =
      {{(XW-COST_BITS+1){1'b0}}, {(COST_BITS-1){1'b1}}};
   localparam logic signed [XW-1:0] COST_MIN_X =
      {{(XW-COST_BITS+1){1'b1}}, {(COST_BITS-1){1'b0}}};

   // Control state
   logic [3:0]          state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   logic [TW-1:0]       total_ff, total_in;
   logic                ovf_ff, ovf_in;
   logic [TW-1:0]       e_ff, e_in;
   logic [CW-1:0]       pass_ff, pass_in;
   logic                chg_ff, chg_in;
   logic [NW-1:0]       clr_ff, clr_in;
   logic [NODE_BITS-1:0] ncount_ff, ncount_in;
   logic [NODE_BITS-1:0] src_ff, src_in;
   logic [NODE_BITS-1:0] tgt_ff, tgt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   // Payload state
   edge_type            rev_ff, rev_in;
   logic signed [DW-1:0] sum_ff, sum_in;
   logic [STATUS_BITS-1:0] stat_ff, stat_in;
   logic signed [COST_BITS-1:0] cost_ff, cost_in;
   logic [STATUS_BITS-1:0] rsp_stat_ff, rsp_stat_in;
   logic signed [COST_BITS-1:0] rsp_cost_ff, rsp_cost_in;

   // Edge store ports
   logic          ew_en;
   logic [EW-1:0] ew_addr;
   edge_type      ew_data;
   logic          er_en;
   edge_type      er_data;

   // Node memory: {mark, reached, distance}
   logic [MW-1:0] node_mem [0:MAX_NODES];
   logic [MW-1:0] na_ff, nb_ff;
   logic          nw_en;
   logic [NW-1:0] nw_addr;
   logic [MW-1:0] nw_data;
   logic          nr_en;
   logic [NW-1:0] nr_a_addr, nr_b_addr;

   // Derived values
   logic [CW-1:0] lim, sweeps, ex_src, ex_dst, ex_srcn, ex_tgt;
   logic          src_ok, dst_ok, srcn_ok, tgt_ok, edge_room, req_xfer, out_free;
   logic signed [DW:0]   sum_full;
   logic signed [DW-1:0] sat_sum;
   logic signed [DW-1:0] dist_a, dist_b;
   logic                 reach_a, reach_b, mark_a, mark_b, relax_ok;
   logic signed [XW-1:0] dist_x;

   bfnc_edge_store #(.MAX_EDGES(MAX_EDGES)) u_store (
      .clock   (clock),
      .wr_en   (ew_en),
      .wr_addr (ew_addr),
      .wr_data (ew_data),
      .rd_en   (er_en),
      .rd_addr (e_ff[EW-1:0]),
      .rd_data (er_data)
   );

   // Node memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (nw_en) begin
         node_mem[nw_addr] <= nw_data;
      end
      if (nr_en) begin
         na_ff <= node_mem[nr_a_addr];
         nb_ff <= node_mem[nr_b_addr];
      end
   end

   // Effective node limit and range checks
   always_comb begin
      lim = (CW'(ncount_ff) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(ncount_ff);
      sweeps  = (lim != '0) ? lim - CW'(1) : '0;
      ex_src  = CW'(er_data.src);
      ex_dst  = CW'(er_data.dst);
      ex_srcn = CW'(src_ff);
      ex_tgt  = CW'(tgt_ff);
      src_ok  = (ex_src != '0) && (ex_src <= lim);
      dst_ok  = (ex_dst != '0) && (ex_dst <= lim);
      srcn_ok = (ex_srcn != '0) && (ex_srcn <= lim);
      tgt_ok  = (ex_tgt != '0) && (ex_tgt <= lim);
      edge_room = (total_ff < TW'(MAX_EDGES));
      req_xfer  = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Saturating add of start distance and edge weight, and relax compare
   always_comb begin
      dist_a  = na_ff[DW-1:0];
      dist_b  = nb_ff[DW-1:0];
      reach_a = na_ff[DW];
      reach_b = nb_ff[DW];
      mark_a  = na_ff[DW+1];
      mark_b  = nb_ff[DW+1];
      sum_full = {dist_a[DW-1], dist_a} + (DW+1)'(er_data.weight);
      if (sum_full[DW] != sum_full[DW-1]) begin
         sat_sum = sum_full[DW] ? DIST_MIN : DIST_MAX;
      end else begin
         sat_sum = sum_full[DW-1:0];
      end
      relax_ok = reach_a && (!reach_b || (sum_ff < dist_b));
      dist_x = XW'(dist_b);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      e_in     = e_ff;
      pass_in  = pass_ff;
      chg_in   = chg_ff;
      clr_in   = clr_ff;
      ncount_in = ncount_ff;
      src_in   = src_ff;
      tgt_in   = tgt_ff;
      rev_in   = rev_ff;
      sum_in   = sum_ff;
      stat_in  = stat_ff;
      cost_in  = cost_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_cost_in  = rsp_cost_ff;
      ew_en   = 1'b0;
      ew_addr = total_ff[EW-1:0];
      ew_data = rev_ff;
      er_en   = 1'b0;
      nw_en   = 1'b0;
      nw_addr = '0;
      nw_data = '0;
      nr_en   = 1'b0;
      nr_a_addr = ex_src[NW-1:0];
      nr_b_addr = ex_dst[NW-1:0];

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Take control register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_NODE_COUNT:  ncount_in = csr_data;
            CSR_SOURCE_NODE: src_in = csr_data;
            CSR_TARGET_NODE: tgt_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_cmd)
                  CMD_LOAD: begin
                     rev_in = '{src: req_edge_to, dst: req_edge_from,
                                weight: req_edge_weight};
                     ew_data = '{src: req_edge_from, dst: req_edge_to,
                                 weight: req_edge_weight};
                     if (edge_room) begin
                        ew_en = 1'b1;
                        total_in = total_ff + TW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (req_both_ways) begin
                        state_in = S_REV;
                     end
                  end
                  CMD_SOLVE: begin
                     if (ovf_ff) begin
                        stat_in  = ST_OVERFLOW;
                        cost_in  = '0;
                        state_in = S_REPORT;
                     end else begin
                        clr_in   = '0;
                        state_in = S_CLR;
                     end
                  end
                  CMD_CLEAR: begin
                     total_in = '0;
                     ovf_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_REV: begin
            // Store the reversed copy of a two-way edge
            if (edge_room) begin
               ew_en = 1'b1;
               total_in = total_ff + TW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_CLR: begin
            nw_en   = 1'b1;
            nw_addr = clr_ff;
            nw_data = '0;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == NW'(MAX_NODES)) begin
               state_in = S_SRC;
            end
         end
         S_SRC: begin
            if (srcn_ok) begin
               nw_en   = 1'b1;
               nw_addr = ex_srcn[NW-1:0];
               nw_data = {1'b0, 1'b1, {DW{1'b0}}};
            end
            e_in     = '0;
            pass_in  = '0;
            chg_in   = 1'b0;
            phase_in = (sweeps == '0) ? PH_CHECK : PH_RELAX;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            if (e_ff == total_ff) begin
               // End of a sweep
               e_in = '0;
               case (phase_ff)
                  PH_RELAX: begin
                     pass_in = pass_ff + CW'(1);
                     if (pass_ff + CW'(1) >= sweeps) begin
                        phase_in = PH_CHECK;
                     end
                  end
                  PH_CHECK: begin
                     phase_in = PH_SPREAD;
                     chg_in   = 1'b0;
                  end
                  default: begin
                     if (chg_ff) begin
                        chg_in = 1'b0;
                     end else begin
                        state_in = S_TGT;
                     end
                  end
               endcase
            end else begin
               er_en    = 1'b1;
               state_in = S_EW;
            end
         end
         S_EW: begin
            if (src_ok && dst_ok) begin
               nr_en    = 1'b1;
               state_in = S_NW;
            end else begin
               e_in     = e_ff + TW'(1);
               state_in = S_EDGE;
            end
         end
         S_NW: begin
            sum_in   = sat_sum;
            state_in = S_CMP;
         end
         S_CMP: begin
            nw_addr = ex_dst[NW-1:0];
            case (phase_ff)
               PH_RELAX: begin
                  nw_en   = relax_ok;
                  nw_data = {mark_b, 1'b1, sum_ff};
               end
               PH_CHECK: begin
                  nw_en   = relax_ok;
                  nw_data = {1'b1, reach_b, dist_b};
               end
               default: begin
                  nw_en   = mark_a && !mark_b;
                  nw_data = {1'b1, reach_b, dist_b};
                  if (mark_a && !mark_b) begin
                     chg_in = 1'b1;
                  end
               end
            endcase
            e_in     = e_ff + TW'(1);
            state_in = S_EDGE;
         end
         S_TGT: begin
            if (tgt_ok) begin
               nr_en     = 1'b1;
               nr_b_addr = ex_tgt[NW-1:0];
               state_in  = S_TW;
            end else begin
               stat_in  = ST_UNREACH;
               cost_in  = '0;
               state_in = S_REPORT;
            end
         end
         S_TW: begin
            cost_in = '0;
            if (!reach_b) begin
               stat_in = ST_UNREACH;
            end else if (mark_b) begin
               stat_in = ST_NEG_INF;
            end else begin
               stat_in = ST_FINITE;
               if (dist_x > COST_MAX_X) begin
                  cost_in = COST_MAX_X[COST_BITS-1:0];
               end else if (dist_x < COST_MIN_X) begin
                  cost_in = COST_MIN_X[COST_BITS-1:0];
               end else begin
                  cost_in = dist_x[COST_BITS-1:0];
               end
            end
            state_in = S_REPORT;
         end
         S_REPORT: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_cost_in  = cost_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_RELAX;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         e_ff         <= '0;
         pass_ff      <= '0;
         chg_ff       <= 1'b0;
         clr_ff       <= '0;
         ncount_ff    <= NODE_BITS'(2);
         src_ff       <= NODE_BITS'(1);
         tgt_ff       <= NODE_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         e_ff         <= e_in;
         pass_ff      <= pass_in;
         chg_ff       <= chg_in;
         clr_ff       <= clr_in;
         ncount_ff    <= ncount_in;
         src_ff       <= src_in;
         tgt_ff       <= tgt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rev_ff      <= rev_in;
      sum_ff      <= sum_in;
      stat_ff     <= stat_in;
      cost_ff     <= cost_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_status = rsp_stat_ff;
   assign rsp_path_cost   = rsp_cost_ff;

endmodule

[rtl/bfnc_checker.sv]
module bfnc_checker import bfnc_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [CMD_BITS-1:0]         req_cmd,
   input logic                        req_both_ways,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [STATUS_BITS-1:0]      rsp_path_status,
   input logic signed [COST_BITS-1:0] rsp_path_cost
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Cost is zero unless the status is finite
   a_cost_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_path_status != ST_FINITE) |-> rsp_path_cost == '0)
      else $error("nonzero cost with non-finite status");

   // A two-way load keeps the input side busy for the reverse copy
   a_rev_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_LOAD) && req_both_ways
      |=> req_stall)
      else $error("reverse edge cycle missing");

   // A solve keeps the input side busy after its transfer
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_SOLVE) |=> req_stall)
      else $error("input taken during solve");

endmodule

bind bellman_ford_neg_cycle_reach_top bfnc_checker u_bfnc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_cmd         (req_cmd),
   .req_both_ways   (req_both_ways),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_path_status (rsp_path_status),
   .rsp_path_cost   (rsp_path_cost)
);
